[design/tfa_pkg.sv]
// ----------------------------------------------------------------------------
// tfa_pkg
// Shared constants and register codes for the three-anchor trilateration block.
// ----------------------------------------------------------------------------
package tfa_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int SLOPE_FRAC      = 16;   // fraction bits of the slopes
  localparam int AC_LIMIT_BITS   = 44;   // intercepts clamp to +-(2^44 - 1)
  localparam int CFG_ADDR_W      = 3;

  typedef enum logic [0:0] {
    REG_COORD_TOL = 1'b0,
    REG_SLOPE_TOL = 1'b1
  } reg_idx_t;

  localparam logic [7:0]  COORD_TOL_RST = 8'd3;
  localparam logic [15:0] SLOPE_TOL_RST = 16'd655;

endpackage

[design/tfa_div.sv]
// ----------------------------------------------------------------------------
// tfa_div
// Pipelined unsigned restoring divider, one quotient bit per stage, several
// lanes sharing one valid and one sideband pipe.
// ----------------------------------------------------------------------------
module tfa_div #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num [LANES],
  input  logic [DEN_W-1:0]  den [LANES],
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo [LANES],
  output logic [SIDE_W-1:0] side_out
);

  logic [NUM_W-1:0]  nq  [NUM_W][LANES];  // numerator bits left, quotient in
  logic [DEN_W-1:0]  rem [NUM_W][LANES];
  logic [DEN_W-1:0]  dv  [NUM_W][LANES];
  logic [SIDE_W-1:0] sd  [NUM_W];
  logic [NUM_W-1:0]  vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_W-2:0], in_valid};
    end
  end

  genvar g, l;
  generate
    for (g = 0; g < NUM_W; g++) begin : g_stage
      always_ff @(posedge clk) begin
        if (en) begin
          sd[g] <= (g == 0) ? side_in : sd[(g == 0) ? 0 : g-1];
        end
      end
      for (l = 0; l < LANES; l++) begin : g_lane
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] dv_in;
        logic [DEN_W+1:0] trial;
        if (g == 0) begin : g_first
          assign nq_in  = num[l];
          assign rem_in = '0;
          assign dv_in  = den[l];
        end else begin : g_next
          assign nq_in  = nq[g-1][l];
          assign rem_in = rem[g-1][l];
          assign dv_in  = dv[g-1][l];
        end
        assign trial = {1'b0, rem_in, nq_in[NUM_W-1]} - (DEN_W+2)'(dv_in);
        always_ff @(posedge clk) begin
          if (en) begin
            rem[g][l] <= trial[DEN_W+1] ? {rem_in[DEN_W-2:0], nq_in[NUM_W-1]}
                                        : trial[DEN_W-1:0];
            nq[g][l]  <= {nq_in[NUM_W-2:0], ~trial[DEN_W+1]};
            dv[g][l]  <= dv_in;
          end
        end
      end
    end
    for (l = 0; l < LANES; l++) begin : g_quo
      assign quo[l] = nq[NUM_W-1][l];
    end
  endgenerate

  assign out_valid = vld[NUM_W-1];
  assign side_out  = sd[NUM_W-1];

endmodule

[design/trilateration_from_three_anchors_top.sv]
// ----------------------------------------------------------------------------
// trilateration_from_three_anchors_top
// Planar position fix from three anchors with measured ranges.
// ----------------------------------------------------------------------------
// One word in per clock unless a stall at m_tready holds the pipe, one word
// out per word in, no state between words. The pipe has two bit-per-stage
// divider pipelines: one solves the two intercepts and two slopes side by
// side, the second solves y. The whole pipe advances whenever the output
// register is empty or being taken, so a stall at m_tready holds every stage
// and drops nothing. The tolerances are read as a word passes the compare
// stages; write them only while idle. Degenerate geometry (all x equal, zero
// x gap, parallel slopes) gives found = 0 with pos_x = pos_y = 0.
// ----------------------------------------------------------------------------
module trilateration_from_three_anchors_top
  import tfa_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // anchors in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // a_x, a_y, a_range, b_x, b_y, b_range, c_x, c_y, c_range, zero pad
  input  logic [((9*COORD_WIDTH-3+7)/8)*8-1:0] s_tdata,
  // position out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pos_x, pos_y, found, zero pad
  output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] m_tdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int OUT_W  = ((2*CW+1+7)/8)*8;
  localparam int OFF_AY = CW;
  localparam int OFF_AD = 2*CW;
  localparam int OFF_BX = 3*CW-1;
  localparam int OFF_BY = 4*CW-1;
  localparam int OFF_BD = 5*CW-1;
  localparam int OFF_CX = 6*CW-2;
  localparam int OFF_CY = 7*CW-2;
  localparam int OFF_CD = 8*CW-2;
  localparam int DX_W   = CW+1;
  localparam int SQ_W   = 2*CW-1;
  localparam int K_W    = 2*CW+1;
  localparam int KD_W   = 2*CW+2;
  localparam int NA_W   = 2*CW+1;
  localparam int BM_W   = CW+SLOPE_FRAC;
  localparam int DV_N   = (NA_W > BM_W) ? NA_W : BM_W;
  localparam int DV_D   = CW+1;
  localparam int QS_W   = DV_N+1;
  localparam int AC_W   = AC_LIMIT_BITS+1;
  localparam int CMP_W  = (QS_W > AC_W) ? QS_W : AC_W;
  localparam int B_W    = BM_W+1;
  localparam int DF_W   = B_W+1;
  localparam int DFM_W  = B_W;
  localparam int CA_W   = AC_W+1;
  localparam int YN_W   = AC_W+SLOPE_FRAC;
  localparam int YS_W   = 2+AC_W+B_W;
  localparam int BL_W   = BM_W/2;
  localparam int BH_W   = BM_W-BL_W;
  localparam int PM_W   = BM_W+CW;
  localparam int TM_W   = PM_W-SLOPE_FRAC;
  localparam int XS_W   = ((AC_W > TM_W+1) ? AC_W : TM_W+1) + 1;

  localparam logic signed [CMP_W-1:0] ACMAX =
    CMP_W'((64'(1) << AC_LIMIT_BITS) - 64'(1));
  localparam logic [CW-1:0] YPOS = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] YNEG = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [XS_W-1:0] XMAX = XS_W'(2**(CW-1)-1);
  localparam logic signed [XS_W-1:0] XMIN = -XMAX - XS_W'(1);

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [7:0]  coord_tol;
  logic [15:0] slope_tol;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_tol <= COORD_TOL_RST;
      slope_tol <= SLOPE_TOL_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_COORD_TOL: coord_tol <= pwdata[7:0];
        REG_SLOPE_TOL: slope_tol <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COORD_TOL: prdata = 32'(coord_tol);
      REG_SLOPE_TOL: prdata = 32'(slope_tol);
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipe control: every stage moves together
  // --------------------------------------------------------------------------
  logic       en;
  logic [6:0] vp;   // stages before the first divider
  logic       vdiv1;
  logic [3:0] ve;   // between the dividers
  logic       vdiv2;
  logic [5:0] vf;   // after the y divider

  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;
  assign m_tvalid = vf[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
      ve <= '0;
      vf <= '0;
    end else if (en) begin
      vp <= {vp[5:0], s_tvalid};
      ve <= {ve[2:0], vdiv1};
      vf <= {vf[4:0], vdiv2};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture, pairwise x differences
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]   in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
  logic signed [CW-1:0]   s1_ax, s1_ay, s1_bx, s1_by, s1_cx, s1_cy;
  logic [CW-2:0]          s1_ad, s1_bd, s1_cd;
  logic signed [DX_W-1:0] s1_dab, s1_dac, s1_dbc;

  assign in_ax = s_tdata[0      +: CW];
  assign in_ay = s_tdata[OFF_AY +: CW];
  assign in_bx = s_tdata[OFF_BX +: CW];
  assign in_by = s_tdata[OFF_BY +: CW];
  assign in_cx = s_tdata[OFF_CX +: CW];
  assign in_cy = s_tdata[OFF_CY +: CW];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax  <= in_ax;
      s1_ay  <= in_ay;
      s1_bx  <= in_bx;
      s1_by  <= in_by;
      s1_cx  <= in_cx;
      s1_cy  <= in_cy;
      s1_ad  <= s_tdata[OFF_AD +: CW-1];
      s1_bd  <= s_tdata[OFF_BD +: CW-1];
      s1_cd  <= s_tdata[OFF_CD +: CW-1];
      s1_dab <= DX_W'(in_ax) - DX_W'(in_bx);
      s1_dac <= DX_W'(in_ax) - DX_W'(in_cx);
      s1_dbc <= DX_W'(in_bx) - DX_W'(in_cx);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: x equality within tolerance (|d| < tol as two compares)
  // --------------------------------------------------------------------------
  logic signed [DX_W-1:0] ctol;
  logic signed [CW-1:0]   s2_ax, s2_ay, s2_bx, s2_by, s2_cx, s2_cy;
  logic [CW-2:0]          s2_ad, s2_bd, s2_cd;
  logic signed [DX_W-1:0] s2_dab, s2_dac, s2_dbc;
  logic                   s2_eq_ab, s2_eq_ac;

  assign ctol = DX_W'({1'b0, coord_tol});

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ax    <= s1_ax;
      s2_ay    <= s1_ay;
      s2_bx    <= s1_bx;
      s2_by    <= s1_by;
      s2_cx    <= s1_cx;
      s2_cy    <= s1_cy;
      s2_ad    <= s1_ad;
      s2_bd    <= s1_bd;
      s2_cd    <= s1_cd;
      s2_dab   <= s1_dab;
      s2_dac   <= s1_dac;
      s2_dbc   <= s1_dbc;
      s2_eq_ab <= (s1_dab < ctol) && (s1_dab > -ctol);
      s2_eq_ac <= (s1_dac < ctol) && (s1_dac > -ctol);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: reference pick, x gaps, y gaps
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]   sel_rx, sel_ry, sel_jx, sel_jy, sel_kx, sel_ky;
  logic [CW-2:0]          sel_rd, sel_jd, sel_kd;
  logic signed [DX_W-1:0] sel_dxj, sel_dxk;
  logic signed [CW-1:0]   s3_rx, s3_ry, s3_jx, s3_jy, s3_kx, s3_ky;
  logic [CW-2:0]          s3_rd, s3_jd, s3_kd;
  logic signed [DX_W-1:0] s3_dxj, s3_dxk, s3_dyj, s3_dyk;
  logic                   s3_fail;

  always_comb begin
    if (!s2_eq_ab && !s2_eq_ac) begin
      sel_rx = s2_ax; sel_ry = s2_ay; sel_rd = s2_ad;
      sel_jx = s2_bx; sel_jy = s2_by; sel_jd = s2_bd;
      sel_kx = s2_cx; sel_ky = s2_cy; sel_kd = s2_cd;
      sel_dxj = s2_dab;
      sel_dxk = s2_dac;
    end else if (s2_eq_ab) begin
      sel_rx = s2_cx; sel_ry = s2_cy; sel_rd = s2_cd;
      sel_jx = s2_bx; sel_jy = s2_by; sel_jd = s2_bd;
      sel_kx = s2_ax; sel_ky = s2_ay; sel_kd = s2_ad;
      sel_dxj = -s2_dbc;
      sel_dxk = -s2_dac;
    end else begin
      sel_rx = s2_bx; sel_ry = s2_by; sel_rd = s2_bd;
      sel_jx = s2_ax; sel_jy = s2_ay; sel_jd = s2_ad;
      sel_kx = s2_cx; sel_ky = s2_cy; sel_kd = s2_cd;
      sel_dxj = -s2_dab;
      sel_dxk = s2_dbc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rx   <= sel_rx;
      s3_ry   <= sel_ry;
      s3_rd   <= sel_rd;
      s3_jx   <= sel_jx;
      s3_jy   <= sel_jy;
      s3_jd   <= sel_jd;
      s3_kx   <= sel_kx;
      s3_ky   <= sel_ky;
      s3_kd   <= sel_kd;
      s3_dxj  <= sel_dxj;
      s3_dxk  <= sel_dxk;
      s3_dyj  <= DX_W'(sel_jy) - DX_W'(sel_ry);
      s3_dyk  <= DX_W'(sel_ky) - DX_W'(sel_ry);
      s3_fail <= s2_eq_ab && s2_eq_ac;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: squares, gap magnitudes and signs
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0] s4_rx2, s4_ry2, s4_rd2, s4_jx2, s4_jy2, s4_jd2;
  logic [SQ_W-1:0] s4_kx2, s4_ky2, s4_kd2;
  logic [CW-1:0]   s4_dxjm, s4_dxkm, s4_dyjm, s4_dykm;
  logic            s4_dxjn, s4_dxkn, s4_dyjn, s4_dykn, s4_fail;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_rx2  <= SQ_W'(s3_rx * s3_rx);
      s4_ry2  <= SQ_W'(s3_ry * s3_ry);
      s4_rd2  <= SQ_W'(s3_rd * s3_rd);
      s4_jx2  <= SQ_W'(s3_jx * s3_jx);
      s4_jy2  <= SQ_W'(s3_jy * s3_jy);
      s4_jd2  <= SQ_W'(s3_jd * s3_jd);
      s4_kx2  <= SQ_W'(s3_kx * s3_kx);
      s4_ky2  <= SQ_W'(s3_ky * s3_ky);
      s4_kd2  <= SQ_W'(s3_kd * s3_kd);
      s4_dxjn <= s3_dxj[DX_W-1];
      s4_dxkn <= s3_dxk[DX_W-1];
      s4_dyjn <= s3_dyj[DX_W-1];
      s4_dykn <= s3_dyk[DX_W-1];
      s4_dxjm <= CW'(s3_dxj[DX_W-1] ? -s3_dxj : s3_dxj);
      s4_dxkm <= CW'(s3_dxk[DX_W-1] ? -s3_dxk : s3_dxk);
      s4_dyjm <= CW'(s3_dyj[DX_W-1] ? -s3_dyj : s3_dyj);
      s4_dykm <= CW'(s3_dyk[DX_W-1] ? -s3_dyk : s3_dyk);
      s4_fail <= s3_fail || (s3_dxj == '0) || (s3_dxk == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: K = x^2 + y^2 - d^2 per anchor
  // --------------------------------------------------------------------------
  logic signed [K_W-1:0] s5_kr, s5_kj, s5_kk;
  logic [CW-1:0]         s5_dxjm, s5_dxkm, s5_dyjm, s5_dykm;
  logic                  s5_dxjn, s5_dxkn, s5_dyjn, s5_dykn, s5_fail;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_kr   <= K_W'(s4_rx2) + K_W'(s4_ry2) - K_W'(s4_rd2);
      s5_kj   <= K_W'(s4_jx2) + K_W'(s4_jy2) - K_W'(s4_jd2);
      s5_kk   <= K_W'(s4_kx2) + K_W'(s4_ky2) - K_W'(s4_kd2);
      s5_dxjm <= s4_dxjm;
      s5_dxkm <= s4_dxkm;
      s5_dyjm <= s4_dyjm;
      s5_dykm <= s4_dykm;
      s5_dxjn <= s4_dxjn;
      s5_dxkn <= s4_dxkn;
      s5_dyjn <= s4_dyjn;
      s5_dykn <= s4_dykn;
      s5_fail <= s4_fail;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: intercept numerators
  // --------------------------------------------------------------------------
  logic signed [KD_W-1:0] s6_na, s6_nc;
  logic [CW-1:0]          s6_dxjm, s6_dxkm, s6_dyjm, s6_dykm;
  logic                   s6_dxjn, s6_dxkn, s6_dyjn, s6_dykn, s6_fail;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_na   <= KD_W'(s5_kr) - KD_W'(s5_kj);
      s6_nc   <= KD_W'(s5_kr) - KD_W'(s5_kk);
      s6_dxjm <= s5_dxjm;
      s6_dxkm <= s5_dxkm;
      s6_dyjm <= s5_dyjm;
      s6_dykm <= s5_dykm;
      s6_dxjn <= s5_dxjn;
      s6_dxkn <= s5_dxkn;
      s6_dyjn <= s5_dyjn;
      s6_dykn <= s5_dykn;
      s6_fail <= s5_fail;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: divider operands as magnitudes, quotient signs aside
  // --------------------------------------------------------------------------
  logic [DV_N-1:0] s7_num [4];   // A, B, C, D
  logic [DV_D-1:0] s7_den [4];
  logic [4:0]      s7_side;      // fail, sign A, sign B, sign C, sign D

  always_ff @(posedge clk) begin
    if (en) begin
      s7_num[0] <= DV_N'(s6_na[KD_W-1] ? -s6_na : s6_na);
      s7_den[0] <= DV_D'({s6_dxjm, 1'b0});
      s7_num[1] <= DV_N'({s6_dyjm, {SLOPE_FRAC{1'b0}}});
      s7_den[1] <= DV_D'(s6_dxjm);
      s7_num[2] <= DV_N'(s6_nc[KD_W-1] ? -s6_nc : s6_nc);
      s7_den[2] <= DV_D'({s6_dxkm, 1'b0});
      s7_num[3] <= DV_N'({s6_dykm, {SLOPE_FRAC{1'b0}}});
      s7_den[3] <= DV_D'(s6_dxkm);
      s7_side   <= {s6_fail,
                    s6_na[KD_W-1] ^ s6_dxjn,
                    s6_dyjn ^ s6_dxjn,
                    s6_nc[KD_W-1] ^ s6_dxkn,
                    s6_dykn ^ s6_dxkn};
    end
  end

  // --------------------------------------------------------------------------
  // Intercepts and slopes: four lanes, one bit a stage
  // --------------------------------------------------------------------------
  logic [DV_N-1:0] q1 [4];
  logic [4:0]      q1_side;

  tfa_div #(
    .NUM_W  (DV_N),
    .DEN_W  (DV_D),
    .LANES  (4),
    .SIDE_W (5)
  ) u_div_abcd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vp[6]),
    .num       (s7_num),
    .den       (s7_den),
    .side_in   (s7_side),
    .out_valid (vdiv1),
    .quo       (q1),
    .side_out  (q1_side)
  );

  // --------------------------------------------------------------------------
  // E1: signed quotients
  // --------------------------------------------------------------------------
  logic signed [QS_W-1:0] e1_a, e1_c;
  logic signed [B_W-1:0]  e1_b, e1_d;
  logic                   e1_fail;

  always_ff @(posedge clk) begin
    if (en) begin
      e1_a    <= q1_side[3] ? -QS_W'(q1[0]) : QS_W'(q1[0]);
      e1_b    <= q1_side[2] ? -B_W'(q1[1])  : B_W'(q1[1]);
      e1_c    <= q1_side[1] ? -QS_W'(q1[2]) : QS_W'(q1[2]);
      e1_d    <= q1_side[0] ? -B_W'(q1[3])  : B_W'(q1[3]);
      e1_fail <= q1_side[4];
    end
  end

  // --------------------------------------------------------------------------
  // E2: clamp intercepts, slope difference
  // --------------------------------------------------------------------------
  logic signed [CMP_W-1:0] a_ext, c_ext;
  logic signed [AC_W-1:0]  e2_a, e2_c;
  logic signed [B_W-1:0]   e2_b;
  logic signed [DF_W-1:0]  e2_diff;
  logic                    e2_fail;

  assign a_ext = CMP_W'(e1_a);
  assign c_ext = CMP_W'(e1_c);

  always_ff @(posedge clk) begin
    if (en) begin
      if (a_ext > ACMAX)       e2_a <= AC_W'(ACMAX);
      else if (a_ext < -ACMAX) e2_a <= AC_W'(-ACMAX);
      else                     e2_a <= AC_W'(a_ext);
      if (c_ext > ACMAX)       e2_c <= AC_W'(ACMAX);
      else if (c_ext < -ACMAX) e2_c <= AC_W'(-ACMAX);
      else                     e2_c <= AC_W'(c_ext);
      e2_b    <= e1_b;
      e2_diff <= DF_W'(e1_b) - DF_W'(e1_d);
      e2_fail <= e1_fail;
    end
  end

  // --------------------------------------------------------------------------
  // E3: |B - D|, C - A
  // --------------------------------------------------------------------------
  logic [DFM_W-1:0]       e3_dmag;
  logic                   e3_dneg, e3_fail;
  logic signed [CA_W-1:0] e3_ca;
  logic signed [AC_W-1:0] e3_a;
  logic signed [B_W-1:0]  e3_b;

  always_ff @(posedge clk) begin
    if (en) begin
      e3_dmag <= DFM_W'(e2_diff[DF_W-1] ? -e2_diff : e2_diff);
      e3_dneg <= e2_diff[DF_W-1];
      e3_ca   <= CA_W'(e2_c) - CA_W'(e2_a);
      e3_a    <= e2_a;
      e3_b    <= e2_b;
      e3_fail <= e2_fail;
    end
  end

  // --------------------------------------------------------------------------
  // E4: parallel-slope check, y operands
  // --------------------------------------------------------------------------
  logic [YN_W-1:0]  e4_num [1];
  logic [DFM_W-1:0] e4_den [1];
  logic [YS_W-1:0]  e4_side;     // fail, y sign, A, B

  always_ff @(posedge clk) begin
    if (en) begin
      e4_num[0] <= {AC_W'(e3_ca[CA_W-1] ? -e3_ca : e3_ca), {SLOPE_FRAC{1'b0}}};
      e4_den[0] <= e3_dmag;
      e4_side   <= {e3_fail || (e3_dmag == '0) || (e3_dmag < DFM_W'(slope_tol)),
                    e3_ca[CA_W-1] ^ e3_dneg, e3_a, e3_b};
    end
  end

  // --------------------------------------------------------------------------
  // y = (C - A) / (B - D)
  // --------------------------------------------------------------------------
  logic [YN_W-1:0] q2 [1];
  logic [YS_W-1:0] q2_side;

  tfa_div #(
    .NUM_W  (YN_W),
    .DEN_W  (DFM_W),
    .LANES  (1),
    .SIDE_W (YS_W)
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ve[3]),
    .num       (e4_num),
    .den       (e4_den),
    .side_in   (e4_side),
    .out_valid (vdiv2),
    .quo       (q2),
    .side_out  (q2_side)
  );

  // --------------------------------------------------------------------------
  // F1: saturate |y| (one more on the negative side)
  // --------------------------------------------------------------------------
  logic [CW-1:0]          ylim;
  logic [CW-1:0]          f1_ym;
  logic                   f1_ysign, f1_fail;
  logic signed [AC_W-1:0] f1_a;
  logic signed [B_W-1:0]  f1_b;

  assign ylim = q2_side[YS_W-2] ? YNEG : YPOS;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ym    <= (q2[0] > YN_W'(ylim)) ? ylim : CW'(q2[0]);
      f1_ysign <= q2_side[YS_W-2];
      f1_fail  <= q2_side[YS_W-1];
      f1_a     <= q2_side[B_W +: AC_W];
      f1_b     <= q2_side[B_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // F2: signed y, |B|, product sign
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]   f2_y;
  logic [CW-1:0]          f2_ym;
  logic [BM_W-1:0]        f2_bm;
  logic                   f2_pneg, f2_fail;
  logic signed [AC_W-1:0] f2_a;

  always_ff @(posedge clk) begin
    if (en) begin
      f2_y    <= f1_ysign ? -f1_ym : f1_ym;
      f2_ym   <= f1_ym;
      f2_bm   <= BM_W'(f1_b[B_W-1] ? -f1_b : f1_b);
      f2_pneg <= f1_b[B_W-1] != (f1_ysign && (f1_ym != '0));
      f2_fail <= f1_fail;
      f2_a    <= f1_a;
    end
  end

  // --------------------------------------------------------------------------
  // F3: |B|*|y| as two partial products
  // --------------------------------------------------------------------------
  logic [BL_W+CW-1:0]     f3_pl;
  logic [BH_W+CW-1:0]     f3_ph;
  logic signed [CW-1:0]   f3_y;
  logic                   f3_pneg, f3_fail;
  logic signed [AC_W-1:0] f3_a;

  always_ff @(posedge clk) begin
    if (en) begin
      f3_pl   <= f2_bm[BL_W-1:0] * f2_ym;
      f3_ph   <= f2_bm[BM_W-1:BL_W] * f2_ym;
      f3_y    <= f2_y;
      f3_pneg <= f2_pneg;
      f3_fail <= f2_fail;
      f3_a    <= f2_a;
    end
  end

  // --------------------------------------------------------------------------
  // F4: sum partials, drop slope fraction (magnitude, so toward zero)
  // --------------------------------------------------------------------------
  logic [PM_W-1:0]        pmag;
  logic [TM_W-1:0]        f4_term;
  logic signed [CW-1:0]   f4_y;
  logic                   f4_pneg, f4_fail;
  logic signed [AC_W-1:0] f4_a;

  assign pmag = PM_W'(f3_pl) + (PM_W'(f3_ph) << BL_W);

  always_ff @(posedge clk) begin
    if (en) begin
      f4_term <= pmag[PM_W-1:SLOPE_FRAC];
      f4_y    <= f3_y;
      f4_pneg <= f3_pneg;
      f4_fail <= f3_fail;
      f4_a    <= f3_a;
    end
  end

  // --------------------------------------------------------------------------
  // F5: x = A +- term
  // --------------------------------------------------------------------------
  logic signed [XS_W-1:0] term_ext;
  logic signed [XS_W-1:0] f5_x;
  logic signed [CW-1:0]   f5_y;
  logic                   f5_fail;

  assign term_ext = XS_W'(f4_term);

  always_ff @(posedge clk) begin
    if (en) begin
      f5_x    <= f4_pneg ? XS_W'(f4_a) - term_ext : XS_W'(f4_a) + term_ext;
      f5_y    <= f4_y;
      f5_fail <= f4_fail;
    end
  end

  // --------------------------------------------------------------------------
  // F6: saturate x, output register
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] o_x, o_y;
  logic                 o_found;

  always_ff @(posedge clk) begin
    if (en) begin
      if (f5_fail)           o_x <= '0;
      else if (f5_x > XMAX)  o_x <= CW'(XMAX);
      else if (f5_x < XMIN)  o_x <= CW'(XMIN);
      else                   o_x <= CW'(f5_x);
      o_y     <= f5_fail ? '0 : f5_y;
      o_found <= ~f5_fail;
    end
  end

  assign m_tdata = OUT_W'({o_found, o_y, o_x});

endmodule
